// ===== sv/rrjs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrjs_pkg: shared types and constants of the round-robin job scheduler
// Holds the job record, the controller command and status bundles, register
// indexes and the widths that follow from the job capacity.
// ----------------------------------------------------------------------------
package rrjs_pkg;

    localparam int MAX_JOBS = 64;
    localparam int IDX_W    = $clog2(MAX_JOBS);
    localparam int CNT_W    = IDX_W + 1;
    localparam int CLK_W    = 15;
    localparam int SLICE_W  = 8;
    localparam int CFG_W    = 15;

    localparam logic [CLK_W-1:0]   CLOCK_MAX       = 15'h7FFF;
    localparam logic [SLICE_W-1:0] SLICE_RESET     = 8'd4;
    localparam logic [CLK_W-1:0]   LIMIT_RESET     = 15'd120;
    localparam logic [CNT_W-1:0]   CAPACITY        = CNT_W'(MAX_JOBS);

    // Configuration register indexes.
    localparam logic CFG_TIME_SLICE = 1'b0;
    localparam logic CFG_TIME_LIMIT = 1'b1;

    // Class codes.
    localparam logic CLASS_FACULTY = 1'b0;

    // Entry of a per-class list.
    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  arr;
        logic [7:0]  burst;
    } class_entry_t;

    // Entry of the merged list, with its run state.
    typedef struct packed {
        logic [15:0]      id;
        logic             cls;
        logic [7:0]       arr;
        logic [7:0]       burst;
        logic [7:0]       rem;
        logic [CLK_W-1:0] comp;
        logic             fin;
    } merged_entry_t;

    // Read address selection for the merged list.
    typedef enum logic [1:0] {
        RD_ZERO = 2'b00,
        RD_IDX  = 2'b01,
        RD_ADM  = 2'b10
    } rd_sel_t;

    typedef struct packed {
        logic    load;
        logic    push_f;
        logic    push_s;
        logic    run_set;
        logic    idx_clr;
        logic    idx_inc;
        logic    slice;
        logic    adm_inc;
        logic    clk_jump;
        logic    emit;
        logic    clear;
        rd_sel_t rd_sel;
    } cmd_t;

    typedef struct packed {
        logic f_av;
        logic s_av;
        logic f_le_s;
        logic f_eq_s;
        logic run_ok;
        logic idx_last;
        logic adm_lt_mc;
        logic arr_le_clk;
        logic idle_jump;
        logic out_last;
    } status_t;

endpackage

// ===== sv/rrjs_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrjs_ctrl: sequencing state machine of the round-robin job scheduler
// Steps through loading, the merge of the two class lists, the slice passes
// with admission and the result readout, driving the datapath by commands.
// ----------------------------------------------------------------------------
module rrjs_ctrl
    import rrjs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    last_job,
    input  status_t st,
    output cmd_t    cmd,
    output logic    busy
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_M_RD   = 14'b00000000000010,
        S_M_SEL  = 14'b00000000000100,
        S_M_PAIR = 14'b00000000001000,
        S_R_INIT = 14'b00000000010000,
        S_R_SET  = 14'b00000000100000,
        S_P_CHK  = 14'b00000001000000,
        S_P_RD   = 14'b00000010000000,
        S_P_EXE  = 14'b00000100000000,
        S_A_RD   = 14'b00001000000000,
        S_A_CHK  = 14'b00010000000000,
        S_I_CHK  = 14'b00100000000000,
        S_O_RD   = 14'b01000000000000,
        S_O_EMIT = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_ADM;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (last_job)
                    begin
                        state_next = S_M_RD;
                    end
                end
            end
            S_M_RD:
            begin
                state_next = S_M_SEL;
            end
            S_M_SEL:
            begin
                if (st.f_av && (!st.s_av || st.f_le_s))
                begin
                    cmd.push_f = 1'b1;
                    state_next = (st.s_av && st.f_eq_s) ? S_M_PAIR : S_M_RD;
                end
                else if (st.s_av)
                begin
                    cmd.push_s = 1'b1;
                    state_next = S_M_RD;
                end
                else
                begin
                    state_next = S_R_INIT;
                end
            end
            S_M_PAIR:
            begin
                cmd.push_s = 1'b1;
                state_next = S_M_RD;
            end
            S_R_INIT:
            begin
                cmd.rd_sel = RD_ZERO;
                state_next = S_R_SET;
            end
            S_R_SET:
            begin
                cmd.rd_sel  = RD_ZERO;
                cmd.run_set = 1'b1;
                state_next  = S_P_CHK;
            end
            S_P_CHK:
            begin
                cmd.idx_clr = 1'b1;
                state_next  = st.run_ok ? S_P_RD : S_O_RD;
            end
            S_P_RD:
            begin
                cmd.rd_sel = RD_IDX;
                state_next = S_P_EXE;
            end
            S_P_EXE:
            begin
                cmd.rd_sel  = RD_IDX;
                cmd.slice   = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = st.idx_last ? S_A_RD : S_P_RD;
            end
            S_A_RD:
            begin
                state_next = st.adm_lt_mc ? S_A_CHK : S_I_CHK;
            end
            S_A_CHK:
            begin
                if (st.arr_le_clk)
                begin
                    cmd.adm_inc = 1'b1;
                    state_next  = S_A_RD;
                end
                else
                begin
                    state_next = S_I_CHK;
                end
            end
            S_I_CHK:
            begin
                if (st.idle_jump)
                begin
                    cmd.clk_jump = 1'b1;
                    state_next   = S_A_RD;
                end
                else
                begin
                    state_next = S_P_CHK;
                end
            end
            S_O_RD:
            begin
                cmd.rd_sel = RD_IDX;
                state_next = S_O_EMIT;
            end
            S_O_EMIT:
            begin
                cmd.rd_sel  = RD_IDX;
                cmd.emit    = 1'b1;
                cmd.idx_inc = 1'b1;
                if (st.out_last)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_O_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/rrjs_datapath.sv =====
// ----------------------------------------------------------------------------
// rrjs_datapath: storage and arithmetic of the round-robin job scheduler
// Holds the class lists, the merged list, counters, the minute clock and
// the configuration registers, and forms the result beat.
// ----------------------------------------------------------------------------
module rrjs_datapath
    import rrjs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output status_t           st,
    input  logic              wr_en,
    input  logic              wr_index,
    input  logic [CFG_W-1:0]  wr_data,
    input  logic              job_class,
    input  logic [15:0]       job_id,
    input  logic [7:0]        arrival,
    input  logic [7:0]        burst,
    output logic              result_valid,
    output logic [15:0]       out_job_id,
    output logic              out_class,
    output logic [7:0]        out_arrival,
    output logic [7:0]        out_burst,
    output logic [CLK_W-1:0]  completion,
    output logic [CLK_W-1:0]  turnaround,
    output logic [CLK_W-1:0]  waiting,
    output logic              finished,
    output logic              last_result
);

    class_entry_t  fac_mem [MAX_JOBS];
    class_entry_t  stu_mem [MAX_JOBS];
    merged_entry_t mrg_mem [MAX_JOBS];

    class_entry_t  fdat_reg, sdat_reg;
    merged_entry_t rdat_reg;

    logic [SLICE_W-1:0] slice_reg;
    logic [CLK_W-1:0]   limit_reg;
    logic [CNT_W-1:0]   fc_reg, sc_reg, fi_reg, si_reg, mc_reg;
    logic [CNT_W-1:0]   adm_reg, done_reg, idx_reg;
    logic [CLK_W-1:0]   clock_reg;

    logic [CNT_W-1:0]   total;
    logic [CNT_W-1:0]   idx_plus;
    logic [IDX_W-1:0]   mrd_addr;
    logic [SLICE_W-1:0] quantum;
    logic               uses_full;
    logic [SLICE_W-1:0] step;
    logic [CLK_W:0]     sum;
    logic [CLK_W-1:0]   clock_adv;
    merged_entry_t      upd;
    merged_entry_t      push_data;
    logic               mrg_we;
    logic [IDX_W-1:0]   mrg_waddr;
    merged_entry_t      mrg_wdata;
    logic [CLK_W-1:0]   ta_calc, wt_calc;
    class_entry_t       new_entry;

    assign total     = fc_reg + sc_reg;
    assign idx_plus  = idx_reg + CNT_W'(1);
    assign new_entry = '{id: job_id, arr: arrival, burst: burst};

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_reg <= SLICE_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_TIME_SLICE: slice_reg <= wr_data[SLICE_W-1:0];
                CFG_TIME_LIMIT: limit_reg <= wr_data;
                default:        slice_reg <= slice_reg;
            endcase
        end
    end

    // Class lists: written while loading, read at the merge heads.
    always_ff @(posedge clk)
    begin
        if (cmd.load && (total < CAPACITY))
        begin
            if (job_class == CLASS_FACULTY)
            begin
                fac_mem[fc_reg[IDX_W-1:0]] <= new_entry;
            end
            else
            begin
                stu_mem[sc_reg[IDX_W-1:0]] <= new_entry;
            end
        end
        fdat_reg <= fac_mem[fi_reg[IDX_W-1:0]];
        sdat_reg <= stu_mem[si_reg[IDX_W-1:0]];
    end

    // Slice arithmetic for the job read from the merged list.
    assign quantum   = (slice_reg == '0) ? SLICE_W'(1) : slice_reg;
    assign uses_full = (rdat_reg.rem > quantum);
    assign step      = uses_full ? quantum : rdat_reg.rem;
    assign sum       = {1'b0, clock_reg} + {{(CLK_W+1-SLICE_W){1'b0}}, step};
    assign clock_adv = sum[CLK_W] ? CLOCK_MAX : sum[CLK_W-1:0];

    always_comb
    begin
        upd = rdat_reg;
        if (uses_full)
        begin
            upd.rem = rdat_reg.rem - quantum;
        end
        else
        begin
            upd.rem  = '0;
            upd.comp = clock_adv;
            upd.fin  = 1'b1;
        end
    end

    always_comb
    begin
        push_data = '0;
        if (cmd.push_f)
        begin
            push_data.id    = fdat_reg.id;
            push_data.cls   = 1'b0;
            push_data.arr   = fdat_reg.arr;
            push_data.burst = fdat_reg.burst;
            push_data.rem   = fdat_reg.burst;
        end
        else
        begin
            push_data.id    = sdat_reg.id;
            push_data.cls   = 1'b1;
            push_data.arr   = sdat_reg.arr;
            push_data.burst = sdat_reg.burst;
            push_data.rem   = sdat_reg.burst;
        end
    end

    assign mrg_we    = cmd.push_f || cmd.push_s || (cmd.slice && !rdat_reg.fin);
    assign mrg_waddr = cmd.slice ? idx_reg[IDX_W-1:0] : mc_reg[IDX_W-1:0];
    assign mrg_wdata = cmd.slice ? upd : push_data;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_ZERO: mrd_addr = '0;
            RD_IDX:  mrd_addr = idx_reg[IDX_W-1:0];
            RD_ADM:  mrd_addr = adm_reg[IDX_W-1:0];
            default: mrd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mrg_we)
        begin
            mrg_mem[mrg_waddr] <= mrg_wdata;
        end
        rdat_reg <= mrg_mem[mrd_addr];
    end

    // Counters and the minute clock.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg    <= '0;
            sc_reg    <= '0;
            fi_reg    <= '0;
            si_reg    <= '0;
            mc_reg    <= '0;
            adm_reg   <= '0;
            done_reg  <= '0;
            idx_reg   <= '0;
            clock_reg <= '0;
        end
        else
        begin
            if (cmd.load && (total < CAPACITY))
            begin
                if (job_class == CLASS_FACULTY)
                begin
                    fc_reg <= fc_reg + CNT_W'(1);
                end
                else
                begin
                    sc_reg <= sc_reg + CNT_W'(1);
                end
            end
            if (cmd.push_f)
            begin
                fi_reg <= fi_reg + CNT_W'(1);
            end
            if (cmd.push_s)
            begin
                si_reg <= si_reg + CNT_W'(1);
            end
            if (cmd.push_f || cmd.push_s)
            begin
                mc_reg <= mc_reg + CNT_W'(1);
            end
            if (cmd.run_set)
            begin
                clock_reg <= {{(CLK_W-8){1'b0}}, rdat_reg.arr};
                adm_reg   <= CNT_W'(1);
                done_reg  <= '0;
            end
            if (cmd.slice && !rdat_reg.fin)
            begin
                clock_reg <= clock_adv;
                if (!uses_full)
                begin
                    done_reg <= done_reg + CNT_W'(1);
                end
            end
            if (cmd.adm_inc)
            begin
                adm_reg <= adm_reg + CNT_W'(1);
            end
            if (cmd.clk_jump && ({{(CLK_W-8){1'b0}}, rdat_reg.arr} > clock_reg))
            begin
                clock_reg <= {{(CLK_W-8){1'b0}}, rdat_reg.arr};
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_plus;
            end
            if (cmd.clear)
            begin
                fc_reg <= '0;
                sc_reg <= '0;
                fi_reg <= '0;
                si_reg <= '0;
                mc_reg <= '0;
            end
        end
    end

    // Status toward the controller.
    assign st.f_av       = (fi_reg < fc_reg);
    assign st.s_av       = (si_reg < sc_reg);
    assign st.f_le_s     = (fdat_reg.arr <= sdat_reg.arr);
    assign st.f_eq_s     = (fdat_reg.arr == sdat_reg.arr);
    assign st.run_ok     = (clock_reg < limit_reg) && (done_reg != mc_reg);
    assign st.idx_last   = (idx_plus == adm_reg);
    assign st.adm_lt_mc  = (adm_reg < mc_reg);
    assign st.arr_le_clk = ({{(CLK_W-8){1'b0}}, rdat_reg.arr} <= clock_reg);
    assign st.idle_jump  = (done_reg == adm_reg) && (adm_reg < mc_reg);
    assign st.out_last   = (idx_plus == mc_reg);

    // Result beat.
    assign ta_calc = (rdat_reg.comp >= {{(CLK_W-8){1'b0}}, rdat_reg.arr}) ?
                     rdat_reg.comp - {{(CLK_W-8){1'b0}}, rdat_reg.arr} : '0;
    assign wt_calc = (ta_calc >= {{(CLK_W-8){1'b0}}, rdat_reg.burst}) ?
                     ta_calc - {{(CLK_W-8){1'b0}}, rdat_reg.burst} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_job_id  <= rdat_reg.id;
            out_class   <= rdat_reg.cls;
            out_arrival <= rdat_reg.arr;
            out_burst   <= rdat_reg.burst;
            completion  <= rdat_reg.fin ? rdat_reg.comp : '0;
            turnaround  <= rdat_reg.fin ? ta_calc : '0;
            waiting     <= rdat_reg.fin ? wt_calc : '0;
            finished    <= rdat_reg.fin;
            last_result <= st.out_last;
        end
    end

endmodule

// ===== sv/round_robin_job_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_job_scheduler: two-class round-robin job scheduler
// Loads faculty and student jobs, merges them by arrival and serves them
// in time-slice passes, then reports one result beat per job.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ------------------------------------------
//  job in    start && !busy         job_class, job_id, arrival, burst, last_job
//  config    wr_en                  wr_index, wr_data
//  result    result_valid (strobe)  out_job_id .. last_result
//
// A job is loaded on each start while idle. The job that carries last_job
// starts the run: the merge reads the list heads, then pushes a job (a pair
// with equal arrival pushes the student job in a further step), each time
// slice reads then executes on the merged list's single read port, each
// admission check reads then compares, and the readout reads then emits each
// result beat. busy rises after the last job and falls in the same cycle in
// which the final beat is on the result ports. Reset clears all counters and
// restores the time slice to 4 and the limit to 120; the job stores hold
// nothing until written. Result beats are strobes and cannot be stalled.
module round_robin_job_scheduler
    import rrjs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              job_class,
    input  logic [15:0]       job_id,
    input  logic [7:0]        arrival,
    input  logic [7:0]        burst,
    input  logic              last_job,
    input  logic              wr_en,
    input  logic              wr_index,
    input  logic [CFG_W-1:0]  wr_data,
    output logic              result_valid,
    output logic [15:0]       out_job_id,
    output logic              out_class,
    output logic [7:0]        out_arrival,
    output logic [7:0]        out_burst,
    output logic [CLK_W-1:0]  completion,
    output logic [CLK_W-1:0]  turnaround,
    output logic [CLK_W-1:0]  waiting,
    output logic              finished,
    output logic              last_result
);

    // Commands from the sequencer and status back from the datapath.
    cmd_t    cmd;
    status_t st;

    // The controller only walks the phases; every compare it branches on is
    // formed in the datapath next to the registers it looks at.
    rrjs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .last_job (last_job),
        .st       (st),
        .cmd      (cmd),
        .busy     (busy)
    );

    // The datapath owns the three job stores, which are read through
    // registered ports, so each decision on a stored job is taken in the cycle after its read.
    rrjs_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .job_class    (job_class),
        .job_id       (job_id),
        .arrival      (arrival),
        .burst        (burst),
        .result_valid (result_valid),
        .out_job_id   (out_job_id),
        .out_class    (out_class),
        .out_arrival  (out_arrival),
        .out_burst    (out_burst),
        .completion   (completion),
        .turnaround   (turnaround),
        .waiting      (waiting),
        .finished     (finished),
        .last_result  (last_result)
    );

endmodule

// ===== sv/rrjs_checker.sv =====
// ----------------------------------------------------------------------------
// rrjs_checker: port-level checks of the round-robin job scheduler
// Watches the job, result and busy ports over time.
// ----------------------------------------------------------------------------
module rrjs_checker
    import rrjs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              last_job,
    input logic              result_valid,
    input logic [CLK_W-1:0]  completion,
    input logic [CLK_W-1:0]  turnaround,
    input logic [CLK_W-1:0]  waiting,
    input logic              finished,
    input logic              last_result
);

    // The final job of a set starts the run.
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last_job |=> busy)
        else $error("last job did not start the run");

    // Beats before the final one come while the block is still busy.
    a_beat_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_result |-> busy)
        else $error("result beat outside a run");

    // Nothing follows the final beat directly.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_result |=> !result_valid)
        else $error("beat after final result");

    // An unfinished job reports zero times.
    a_unfinished_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !finished |->
            completion == '0 && turnaround == '0 && waiting == '0)
        else $error("unfinished job with nonzero times");

endmodule

bind round_robin_job_scheduler rrjs_checker u_rrjs_checker (.*);
